// ----- hdl/aprf_pkg.sv -----
// ----------------------------------------------------------------------------
// aprf_pkg: shared types and codes for the addressed packet receiver/forwarder
// Holds the action codes, parser phases, register indexes and the queue word.
// ----------------------------------------------------------------------------
package aprf_pkg;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_DEST    = 3'd1,
		PH_SRC     = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5,
		PH_END     = 3'd6
	} phase_t;

	localparam logic [1:0] REG_DEV_ID    = 2'd0;
	localparam logic [1:0] REG_START     = 2'd1;
	localparam logic [1:0] REG_END       = 2'd2;
	localparam logic [1:0] REG_FWD_EN    = 2'd3;

	// Front-to-back command word: one per accepted input word.
	typedef struct packed {
		logic [1:0] fwd_count;
		logic [7:0] fwd_first;
		logic [7:0] fwd_second;
		logic [2:0] phase;
		logic       store_wr;   // write payload byte into the store
		logic [7:0] store_pos;  // payload position
		logic [7:0] data;
		logic       commit;     // own frame finished with good checks
		logic       check_own;  // own frame reached its checksum byte
		logic [7:0] frame_len;
		logic       do_read;
		logic       do_release;
		logic [5:0] read_index;
	} cmd_t;

endpackage

// ----- hdl/addressed_packet_receiver_forwarder.sv -----
// ----------------------------------------------------------------------------
// addressed_packet_receiver_forwarder: framed packet parser with forwarding
// Parses start/dest/src/len/payload/checksum/end frames, keeps own packets.
// ----------------------------------------------------------------------------
// One word in, one result word out, at one word per clock while results are
// taken. A front parser classifies each word, a two-entry queue hands the
// command to the back end, which updates the slot store (RX_SLOTS slots of
// MAX_PAYLOAD bytes) and registers the result; each command is held in a queue
// entry, then in the result register. A stalled result holds the back end; the
// queue lets the parser take two more words first. Store entries never written
// read as garbage but are never returned. The store has no clearing pass.
module addressed_packet_receiver_forwarder #(
	parameter int RX_SLOTS    = 4,
	parameter int MAX_PAYLOAD = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // action[1:0], data_byte[9:2], read_index[15:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // fwd_count, fwd_first, fwd_second, accepted,
	                               // dropped, packets_waiting, head_len,
	                               // read_data, parse_phase (low bit up)
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import aprf_pkg::*;

	logic [7:0] dev_id_q, start_q, end_q;
	logic       fwd_en_q;
	logic       q_full, q_nonempty, q_pop, step;
	cmd_t       front_cmd, head_cmd;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign step      = s_tvalid && s_tready;

	// Hold configuration registers; write one per handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q <= 8'hFF;
			start_q  <= 8'd2;
			end_q    <= 8'd3;
			fwd_en_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEV_ID: dev_id_q <= cfg_data;
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				REG_FWD_EN: fwd_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	aprf_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk, .arst_n, .step,
		.action(s_tdata[1:0]), .data_byte(s_tdata[9:2]), .read_index(s_tdata[15:10]),
		.dev_id(dev_id_q), .start_code(start_q), .end_code(end_q),
		.forward_enable(fwd_en_q), .cmd(front_cmd)
	);

	aprf_queue u_queue (
		.clk, .arst_n, .push(step), .push_cmd(front_cmd), .full(q_full),
		.pop(q_pop), .nonempty(q_nonempty), .head(head_cmd)
	);

	aprf_back #(.RX_SLOTS(RX_SLOTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk, .arst_n, .cmd_valid(q_nonempty), .cmd(head_cmd), .cmd_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
	);

`ifndef SYNTHESIS
	// Never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !step) else $error("queue overflow");
	// Never pop an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty) else $error("queue underflow");
	// A stalled result must not advance.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result moved");
`endif

endmodule

// ----- hdl/aprf_front.sv -----
// ----------------------------------------------------------------------------
// aprf_front: frame parser
// Tracks the frame phase and checksum, decides forwarding and store commands.
// ----------------------------------------------------------------------------
module aprf_front #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [1:0]      action,
	input  logic [7:0]      data_byte,
	input  logic [5:0]      read_index,
	input  logic [7:0]      dev_id,
	input  logic [7:0]      start_code,
	input  logic [7:0]      end_code,
	input  logic            forward_enable,
	output aprf_pkg::cmd_t  cmd
);
	import aprf_pkg::*;

	phase_t     phase_q, phase_d;
	logic       own_q, own_d;
	logic [7:0] len_q, len_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] sum_q, sum_d;

	always_comb begin
		phase_d = phase_q;
		own_d   = own_q;
		len_d   = len_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		cmd     = '0;
		cmd.data       = data_byte;
		cmd.read_index = read_index;
		cmd.store_pos  = pos_q;
		cmd.frame_len  = len_q;
		unique case (action_t'(action))
			ACT_BYTE: begin
				if (phase_q == PH_DEST)
					own_d = (data_byte == dev_id);
				if (phase_q != PH_START && !own_d && forward_enable) begin
					if (phase_q == PH_DEST) begin
						cmd.fwd_count  = 2'd2;
						cmd.fwd_first  = start_code;
						cmd.fwd_second = data_byte;
					end else begin
						cmd.fwd_count = 2'd1;
						cmd.fwd_first = data_byte;
					end
				end
				unique case (phase_q)
					PH_START: begin
						if (data_byte == start_code) begin
							own_d   = 1'b0;
							len_d   = '0;
							pos_d   = '0;
							sum_d   = '0;
							phase_d = PH_DEST;
						end
					end
					PH_DEST: begin
						sum_d   = data_byte;
						phase_d = PH_SRC;
					end
					PH_SRC: begin
						sum_d   = sum_q + data_byte;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						len_d   = data_byte;
						pos_d   = '0;
						sum_d   = sum_q + data_byte;
						phase_d = (data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						cmd.store_wr = own_q && (32'(pos_q) < MAX_PAYLOAD);
						sum_d = sum_q + data_byte;
						pos_d = pos_q + 8'd1;
						if (pos_d >= len_q)
							phase_d = PH_CHECK;
					end
					PH_CHECK: begin
						cmd.check_own = own_q;
						cmd.commit    = own_q && (data_byte == sum_q)
							&& (32'(len_q) <= MAX_PAYLOAD);
						phase_d = PH_END;
					end
					default: begin
						if (data_byte == end_code)
							phase_d = PH_START;
					end
				endcase
			end
			ACT_READ:    cmd.do_read    = 1'b1;
			ACT_RELEASE: cmd.do_release = 1'b1;
			default: ;
		endcase
		cmd.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			own_q   <= 1'b0;
			len_q   <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			own_q   <= own_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
		end
	end

endmodule

// ----- hdl/aprf_queue.sv -----
// ----------------------------------------------------------------------------
// aprf_queue: two-entry command queue
// Decouples the parser from the packet store so each side stalls on its own.
// ----------------------------------------------------------------------------
module aprf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aprf_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output aprf_pkg::cmd_t  head
);
	import aprf_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q[1];
	assign nonempty = (cnt_q != 2'd0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- hdl/aprf_back.sv -----
// ----------------------------------------------------------------------------
// aprf_back: packet store and result stage
// Executes queued commands against the slot store and registers each result.
// ----------------------------------------------------------------------------
module aprf_back #(
	parameter int RX_SLOTS    = 4,
	parameter int MAX_PAYLOAD = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  aprf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [47:0]    out_data
);
	import aprf_pkg::*;

	localparam int SW = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
	localparam int CW = $clog2(RX_SLOTS + 1);
	localparam int DEPTH = RX_SLOTS * MAX_PAYLOAD;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] store_q [DEPTH];
	logic [7:0] lens_q [RX_SLOTS];
	logic [SW-1:0] wslot_q, rslot_q;
	logic [CW-1:0] count_q, count_d;
	logic          lost_q;

	// Stage 1: command executed, read data captured.
	logic          v_s1;
	cmd_t          c_s1;
	logic          acc_s1, drop_s1, rd_ok_s1;
	logic [CW-1:0] count_s1;
	logic [6:0]    hlen_s1;
	logic [7:0]    rdata_s1;

	logic adv;
	logic [SW-1:0] wslot_n, rslot_n;
	logic full_now, acc, rd_ok;
	logic [7:0] hlen_cur;
	logic [AW-1:0] waddr, raddr;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		slot_inc = (32'(s) == RX_SLOTS - 1) ? '0 : s + 1'b1;
	endfunction

	assign adv     = !v_s1 || out_ready;
	assign cmd_pop = cmd_valid && adv;

	assign full_now = (32'(count_q) >= RX_SLOTS);
	assign acc      = cmd.commit && !full_now && !lost_q;
	assign hlen_cur = lens_q[rslot_q];
	assign rd_ok    = cmd.do_read && (count_q != '0)
		&& ({2'b0, cmd.read_index} < hlen_cur);
	assign wslot_n  = slot_inc(wslot_q);
	assign rslot_n  = slot_inc(rslot_q);
	assign waddr    = AW'(32'(wslot_q) * MAX_PAYLOAD + 32'(cmd.store_pos));
	assign raddr    = AW'(32'(rslot_q) * MAX_PAYLOAD + 32'(cmd.read_index));

	always_comb begin
		count_d = count_q;
		if (acc)
			count_d = count_q + 1'b1;
		else if (cmd.do_release && count_q != '0)
			count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd.store_wr && !full_now)
				store_q[waddr] <= cmd.data;
			if (acc)
				lens_q[wslot_q] <= cmd.frame_len;
			rdata_s1 <= store_q[raddr];
			c_s1     <= cmd;
			acc_s1   <= acc;
			drop_s1  <= cmd.check_own && !acc;
			rd_ok_s1 <= rd_ok;
			count_s1 <= count_d;
		end
	end

	// Head length sampled after the update, so read it from the new head.
	always_comb begin
		hlen_s1 = (count_q != '0) ? hlen_cur[6:0] : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			rslot_q <= '0;
			count_q <= '0;
			lost_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			if (adv)
				v_s1 <= cmd_pop;
			if (cmd_pop) begin
				count_q <= count_d;
				if (acc)
					wslot_q <= wslot_n;
				if (cmd.do_release && count_q != '0)
					rslot_q <= rslot_n;
				if (cmd.phase == PH_DEST && cmd.fwd_count != 2'd2 && !cmd.check_own)
					lost_q <= 1'b0;
				if (cmd.store_wr && full_now)
					lost_q <= 1'b1;
				if (cmd.check_own)
					lost_q <= 1'b0;
			end
		end
	end

	// Output fields: fwd_count, fwd_first, fwd_second, accepted, dropped,
	// packets_waiting, head_len, read_data, parse_phase.
	assign out_valid = v_s1;
	assign out_data  = {7'b0, c_s1.phase, (rd_ok_s1 ? rdata_s1 : 8'd0), hlen_s1,
		3'(count_s1), drop_s1, acc_s1, c_s1.fwd_second, c_s1.fwd_first,
		c_s1.fwd_count};

endmodule

// ----- dv/addressed_packet_receiver_forwarder_tb.sv -----
// ----------------------------------------------------------------------------
// addressed_packet_receiver_forwarder_tb: self-checking bench for the parser
// Drives framed byte streams, head reads and releases under random flow
// control, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module addressed_packet_receiver_forwarder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aprf_pkg::*;

	localparam int SLOTS    = 4;
	localparam int MAX_PLD  = 64;
	localparam int SETTLE   = 10;      // idle margin after a drain
	localparam int LIMIT    = 600000;  // cycle budget for the whole run

	// Frame tracker and packet store prediction; holds the expected words.
	class packet_scoreboard;
		logic [7:0] dev_id, start_code, end_code;
		logic       fwd_en;
		phase_t     phase;
		bit         own, room_lost;
		logic [7:0] frame_len, pos, sum;
		logic [7:0] store [SLOTS*MAX_PLD];
		logic [6:0] lens [SLOTS];
		int         wr, rd, cnt;
		logic [40:0] pending [$];
		int errors, n_results, n_acc, n_drop, n_fwd;

		function new();
			dev_id = 8'hFF; start_code = 8'd2; end_code = 8'd3; fwd_en = 1'b0;
			phase = PH_START; own = 0; room_lost = 0;
			frame_len = 0; pos = 0; sum = 0;
			wr = 0; rd = 0; cnt = 0;
			errors = 0; n_results = 0; n_acc = 0; n_drop = 0; n_fwd = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				REG_DEV_ID: dev_id = v;
				REG_START:  start_code = v;
				REG_END:    end_code = v;
				REG_FWD_EN: fwd_en = v[0];
			endcase
		endfunction

		// Advance the prediction by one accepted input word.
		function void note_word(logic [15:0] w);
			action_t    act;
			logic [7:0] b, ffirst, fsecond, rdata;
			logic [5:0] ri;
			logic [1:0] fcount;
			logic       acc, drop;
			logic [6:0] hlen;
			act = action_t'(w[1:0]);
			b = w[9:2];
			ri = w[15:10];
			fcount = 0; ffirst = 0; fsecond = 0; acc = 0; drop = 0; rdata = 0;
			if (act == ACT_BYTE) begin
				if (phase == PH_DEST)
					own = (b == dev_id);
				if (phase != PH_START && !own && fwd_en) begin
					if (phase == PH_DEST) begin
						fcount = 2; ffirst = start_code; fsecond = b;
					end else begin
						fcount = 1; ffirst = b;
					end
				end
				case (phase)
					PH_START: begin
						if (b == start_code) begin
							own = 0; frame_len = 0; pos = 0; sum = 0; room_lost = 0;
							phase = PH_DEST;
						end
					end
					PH_DEST: begin
						sum = b;
						phase = PH_SRC;
					end
					PH_SRC: begin
						sum = sum + b;
						phase = PH_LEN;
					end
					PH_LEN: begin
						frame_len = b;
						pos = 0;
						sum = sum + b;
						phase = (b == 0) ? PH_CHECK : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (own) begin
							if (cnt >= SLOTS)
								room_lost = 1;
							else if (pos < MAX_PLD)
								store[wr*MAX_PLD + pos] = b;
						end
						sum = sum + b;
						pos = pos + 8'd1;
						if (pos >= frame_len)
							phase = PH_CHECK;
					end
					PH_CHECK: begin
						if (own) begin
							if (b == sum && frame_len <= MAX_PLD && cnt < SLOTS && !room_lost) begin
								lens[wr] = frame_len[6:0];
								wr = (wr + 1) % SLOTS;
								cnt++;
								acc = 1;
								n_acc++;
							end else begin
								drop = 1;
								n_drop++;
							end
						end
						phase = PH_END;
					end
					default: begin
						if (b == end_code)
							phase = PH_START;
					end
				endcase
			end else if (act == ACT_READ) begin
				if (cnt > 0 && ri < lens[rd])
					rdata = store[rd*MAX_PLD + ri];
			end else if (act == ACT_RELEASE) begin
				if (cnt > 0) begin
					rd = (rd + 1) % SLOTS;
					cnt--;
				end
			end
			n_fwd += fcount;
			hlen = (cnt > 0) ? lens[rd] : 7'd0;
			pending.push_back({phase, rdata, hlen, cnt[2:0], drop, acc, fsecond, ffirst, fcount});
		endfunction

		function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one result word with the oldest expectation.
		function void check_word(logic [47:0] w);
			logic [40:0] e;
			n_results++;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: %h", w);
				errors++;
				return;
			end
			e = pending.pop_front();
			check_field("fwd_count", 8'(e[1:0]), 8'(w[1:0]));
			check_field("fwd_first", e[9:2], w[9:2]);
			check_field("fwd_second", e[17:10], w[17:10]);
			check_field("accepted", 8'(e[18]), 8'(w[18]));
			check_field("dropped", 8'(e[19]), 8'(w[19]));
			check_field("packets_waiting", 8'(e[22:20]), 8'(w[22:20]));
			check_field("head_len", 8'(e[29:23]), 8'(w[29:23]));
			check_field("read_data", e[37:30], w[37:30]);
			check_field("parse_phase", 8'(e[40:38]), 8'(w[40:38]));
			check_field("padding", 8'd0, 8'(w[47:41]));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	packet_scoreboard sb = new();
	int  cycles = 0;
	int  n_sent = 0;
	int  burst_left = 0;
	bit  hold_req = 0;
	bit  no_gaps = 0;
	int  hold_cnt = 0;

	addressed_packet_receiver_forwarder dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both streams; values seen here are the ones the block saw.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_word(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// Receiver stall pattern: the mode steps through four ready patterns; a long
	// hold-off request blocks the output so the input backs up.
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 64) % 4;
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 9) < 3);
				default: m_tready <= cycles[2];
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offer one word and hold it until the block takes it; then maybe gap.
	task automatic send_word(action_t act, logic [7:0] b, logic [5:0] ri);
		s_tvalid <= 1'b1;
		s_tdata <= {ri, b, act};
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 30);
			if (!no_gaps) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Received serial byte; the unused read index is random noise.
	task automatic send_byte(logic [7:0] b);
		send_word(ACT_BYTE, b, 6'($urandom));
	endtask

	task automatic send_read(logic [5:0] ri);
		send_word(ACT_READ, 8'($urandom), ri);
	endtask

	task automatic send_release();
		send_word(ACT_RELEASE, 8'($urandom), 6'($urandom));
	endtask

	// Drain: stop offering, wait for every expected word, then settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		forever begin
			@(negedge clk);
			if (sb.pending.size() == 0) break;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
		end
		@(posedge clk);
		sb.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] id, logic [7:0] st, logic [7:0] en, logic fe);
		drain();
		write_reg(REG_DEV_ID, id);
		write_reg(REG_START, st);
		write_reg(REG_END, en);
		write_reg(REG_FWD_EN, {7'd0, fe});
	endtask

	// Send one full frame. Corrupt the checksum when asked, optionally put
	// junk before the end code and host reads in the middle of the payload.
	task automatic send_frame(logic [7:0] dest, logic [7:0] len, bit bad_sum,
			bit junk, bit mix_reads);
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] src;
		src = 8'($urandom);
		send_byte(sb.start_code);
		send_byte(dest);
		send_byte(src);
		send_byte(len);
		sum = dest + src + len;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum += b;
			send_byte(b);
			if (mix_reads && $urandom_range(0, 3) == 0)
				send_read(6'($urandom));
		end
		send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
		if (junk) begin
			repeat ($urandom_range(1, 4)) begin
				b = 8'($urandom);
				if (b == sb.end_code) b = b + 8'd1;
				send_byte(b);
			end
		end
		send_byte(sb.end_code);
	endtask

	// One random phase: mostly well-formed frames, the rest host actions
	// and noise.
	task automatic random_traffic(int n_items, int hold_at, int pause_at);
		int start_n;
		int r;
		logic [7:0] len, dest;
		start_n = n_sent;
		while (n_sent - start_n < n_items) begin
			if (hold_at >= 0 && n_sent - start_n >= hold_at) begin
				hold_req = 1;
				hold_at = -1;
			end
			if (pause_at >= 0 && n_sent - start_n >= pause_at) begin
				drain();
				pause_at = -1;
			end
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_byte(8'($urandom));
			end else if (r < 20) begin
				send_read(6'($urandom));
			end else if (r < 30) begin
				send_release();
			end else if (r < 33) begin
				send_word(ACT_NONE, 8'($urandom), 6'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 80) len = 8'($urandom_range(0, 8));
				else if (r < 96) len = 8'($urandom_range(9, MAX_PLD));
				else len = 8'($urandom_range(MAX_PLD + 1, MAX_PLD + 6));
				dest = ($urandom_range(0, 1) != 0) ? sb.dev_id : 8'($urandom);
				send_frame(dest, len, $urandom_range(0, 9) == 0,
					$urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
			end
		end
	endtask

	initial begin
		logic [7:0] id;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, forwarding off.
		send_read(6'd0);                 // read with an empty store
		send_release();                  // release with an empty store
		send_word(ACT_NONE, 8'hFF, 6'h3F);
		send_byte(8'h55);                // noise before a start code
		send_frame(8'hFF, 8'd0, 0, 0, 0);   // zero-length own frame
		send_frame(8'hFF, 8'd3, 0, 1, 0);   // own frame, junk before end
		send_read(6'd0);
		send_read(6'd2);
		send_read(6'd3);                 // index past the head length
		send_read(6'd63);
		send_frame(8'hFF, 8'd2, 1, 0, 0);   // bad checksum
		send_frame(8'h05, 8'd1, 0, 0, 0);   // foreign frame, not forwarded
		send_release();
		send_release();

		// Directed: opposite extremes, forwarding on.
		configure(8'h00, 8'hFF, 8'h00, 1'b1);
		send_frame(8'hFF, 8'd2, 0, 1, 0);   // foreign frame forwarded
		send_frame(8'h00, 8'(MAX_PLD + 1), 0, 0, 0);   // too long
		send_frame(8'h00, 8'(MAX_PLD), 0, 0, 0);       // largest that fits
		for (int i = 0; i < SLOTS + 1; i++)
			send_frame(8'h00, 8'd1, 0, 0, 0);   // the last two find the store full
		send_read(6'(MAX_PLD - 1));
		repeat (SLOTS + 1) send_release();
		send_frame(8'h00, 8'd255, 0, 0, 0);   // longest length field

		// Random phases over several settings; one with no sender gaps,
		// one with a long receiver hold-off, one with a mid-phase pause.
		for (int p = 0; p < 6; p++) begin
			id = (p == 0) ? 8'hFF : 8'($urandom);
			configure(id, (p == 1) ? 8'h00 : 8'($urandom),
				(p == 1) ? 8'hFF : 8'($urandom), p[0]);
			no_gaps = (p == 4);
			random_traffic(110, (p == 2) ? 40 : -1, (p == 3) ? 70 : -1);
		end
		no_gaps = 0;
		drain();

		$display("Covered %0d input words, %0d result words, %0d frames stored,",
			n_sent, sb.n_results, sb.n_acc);
		$display("%0d own frames dropped and %0d bytes forwarded.", sb.n_drop, sb.n_fwd);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
